// ===== hdl/mes_pkg.sv =====
package mes_pkg;

  localparam int RADIUS_BITS = 10;

  localparam int CEN_W   = 11;
  localparam int PIX_W   = 12;
  localparam int CFG_W   = (RADIUS_BITS > CEN_W) ? RADIUS_BITS : CEN_W;
  localparam int IDX_W   = 2;
  localparam int STEP_W  = RADIUS_BITS + 1;
  localparam int SQ_W    = 2 * RADIUS_BITS;
  localparam int TX_W    = RADIUS_BITS + 2;
  localparam int MA_W    = 2 * RADIUS_BITS + 4;
  localparam int MB_W    = 2 * RADIUS_BITS;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int SLOPE_W = 3 * RADIUS_BITS + 2;
  localparam int DEC_W   = 4 * RADIUS_BITS + 8;

  typedef enum logic [IDX_W-1:0] {
    REG_RADIUS_X = 2'd0,
    REG_RADIUS_Y = 2'd1,
    REG_CENTRE_X = 2'd2,
    REG_CENTRE_Y = 2'd3
  } cfg_reg_e;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_RX2   = 15'b000000000000010,
    S_RY2   = 15'b000000000000100,
    S_RXY   = 15'b000000000001000,
    S_INIT  = 15'b000000000010000,
    S_CAPRY = 15'b000000000100000,
    S_STEP  = 15'b000000001000000,
    S_TX2   = 15'b000000010000000,
    S_YM2   = 15'b000000100000000,
    S_PA    = 15'b000001000000000,
    S_PB    = 15'b000010000000000,
    S_PC    = 15'b000100000000000,
    S_SUM   = 15'b001000000000000,
    S_ROUND = 15'b010000000000000,
    S_EMIT  = 15'b100000000000000
  } state_e;

  typedef struct packed {
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  // divide by four, half away from zero
  function automatic logic [DEC_W-1:0] quarter_round(logic [DEC_W-1:0] q);
    logic [DEC_W-1:0] m;
    m = '0;
    if (q[DEC_W-1]) begin
      m = -q;
      return -((m + DEC_W'(2)) >> 2);
    end
    return (q + DEC_W'(2)) >> 2;
  endfunction

endpackage

// ===== hdl/mes_mul.sv =====
module mes_mul (
  input  logic                         clk_i,
  input  mes_pkg::mul_req_t            req_i,
  output logic [mes_pkg::PROD_W-1:0]   prod_o
);

  logic [mes_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mes_pkg::PROD_W'(req_i.a) * mes_pkg::PROD_W'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/midpoint_ellipse_stepper.sv =====
// A restart or plain step forms rx^2 and ry^2 afresh on the shared multiplier before
// its result is valid; a step that enters region two also forms the region-two
// decision products. An advance after the walk has finished uses no multiplier. A new
// request is stalled until the sequencer has returned to idle after emitting a result.
// Reset: radii and centre clear to zero, walk state clears with finished set,
// no result pending.
module midpoint_ellipse_stepper (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mes_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [mes_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mes_pkg::PIX_W-1:0]  pix_a_x_o,
  output logic signed [mes_pkg::PIX_W-1:0]  pix_a_y_o,
  output logic signed [mes_pkg::PIX_W-1:0]  pix_b_x_o,
  output logic signed [mes_pkg::PIX_W-1:0]  pix_b_y_o,
  output logic signed [mes_pkg::PIX_W-1:0]  pix_c_x_o,
  output logic signed [mes_pkg::PIX_W-1:0]  pix_c_y_o,
  output logic signed [mes_pkg::PIX_W-1:0]  pix_d_x_o,
  output logic signed [mes_pkg::PIX_W-1:0]  pix_d_y_o,
  output logic                              in_region_two_o,
  output logic                              last_point_o
);

  localparam int R   = mes_pkg::RADIUS_BITS;
  localparam int SW  = mes_pkg::STEP_W;
  localparam int DW  = mes_pkg::DEC_W;
  localparam int LW  = mes_pkg::SLOPE_W;
  localparam int PW  = mes_pkg::PIX_W;

  mes_pkg::state_e state_q, state_d;

  logic [R-1:0]                      radius_x_q, radius_y_q;
  logic signed [mes_pkg::CEN_W-1:0]  centre_x_q, centre_y_q;

  logic [SW-1:0]  step_x_q, step_y_q;
  logic [DW-1:0]  decision_q;
  logic [LW-1:0]  x_slope_q, y_slope_q;
  logic           region_q, finished_q;
  logic           restart_q;

  logic [mes_pkg::SQ_W-1:0]  rx2_q, ry2_q, ym2_q;
  logic [mes_pkg::MA_W-1:0]  tx2_q;
  logic [DW-1:0]             acc_q;

  logic                       out_valid_q;
  logic [PW-1:0]              pax_q, pay_q, pbx_q, pby_q, pcx_q, pcy_q, pdx_q, pdy_q;
  logic                       reg2_out_q, last_out_q;

  mes_pkg::mul_req_t          mul_req;
  logic [mes_pkg::PROD_W-1:0] prod;

  logic                       in_acc, emit_go;
  logic [mes_pkg::TX_W-1:0]   tx;
  logic [SW-1:0]              ym;

  logic [SW-1:0]  nx, ny;
  logic [LW-1:0]  nxs, nys;
  logic [DW-1:0]  ndec;
  logic           r1_step;

  mes_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign in_stall_o = (state_q != mes_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign emit_go    = (state_q == mes_pkg::S_EMIT) && (!out_valid_q || !out_stall_i);

  assign tx = {step_x_q, 1'b1};
  assign ym = step_y_q - SW'(1);

  always_comb begin
    mul_req = '0;
    unique case (state_q)
      mes_pkg::S_RX2: begin
        mul_req.a = mes_pkg::MA_W'(radius_x_q);
        mul_req.b = mes_pkg::MB_W'(radius_x_q);
      end
      mes_pkg::S_RY2: begin
        mul_req.a = mes_pkg::MA_W'(radius_y_q);
        mul_req.b = mes_pkg::MB_W'(radius_y_q);
      end
      mes_pkg::S_RXY: begin
        mul_req.a = mes_pkg::MA_W'(rx2_q);
        mul_req.b = mes_pkg::MB_W'(radius_y_q);
      end
      mes_pkg::S_TX2: begin
        mul_req.a = mes_pkg::MA_W'(tx);
        mul_req.b = mes_pkg::MB_W'(tx);
      end
      mes_pkg::S_YM2: begin
        mul_req.a = mes_pkg::MA_W'(ym);
        mul_req.b = mes_pkg::MB_W'(ym);
      end
      mes_pkg::S_PA: begin
        mul_req.a = tx2_q;
        mul_req.b = ry2_q;
      end
      mes_pkg::S_PB: begin
        mul_req.a = mes_pkg::MA_W'(ym2_q);
        mul_req.b = rx2_q;
      end
      mes_pkg::S_PC: begin
        mul_req.a = mes_pkg::MA_W'(rx2_q);
        mul_req.b = ry2_q;
      end
      default: mul_req = '0;
    endcase
  end

  // one walk step, region one or two
  always_comb begin
    nx      = step_x_q;
    ny      = step_y_q;
    nxs     = x_slope_q;
    nys     = y_slope_q;
    ndec    = decision_q;
    r1_step = !region_q && (x_slope_q < y_slope_q);
    if (r1_step) begin
      nx  = step_x_q + SW'(1);
      nxs = x_slope_q + (LW'(ry2_q) << 1);
      if (decision_q[DW-1]) begin
        ndec = decision_q + DW'(ry2_q) + DW'(nxs);
      end else begin
        ny   = step_y_q - SW'(1);
        nys  = y_slope_q - (LW'(rx2_q) << 1);
        ndec = decision_q + DW'(ry2_q) + DW'(nxs) - DW'(nys);
      end
    end else if (region_q && (step_y_q != '0)) begin
      ny  = step_y_q - SW'(1);
      nys = y_slope_q - (LW'(rx2_q) << 1);
      if (!decision_q[DW-1] && (decision_q != '0)) begin
        ndec = decision_q + DW'(rx2_q) - DW'(nys);
      end else begin
        nx   = step_x_q + SW'(1);
        nxs  = x_slope_q + (LW'(ry2_q) << 1);
        ndec = decision_q + DW'(rx2_q) - DW'(nys) + DW'(nxs);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mes_pkg::S_IDLE: begin
        if (in_acc) begin
          if (!restart_i && finished_q) state_d = mes_pkg::S_EMIT;
          else                          state_d = mes_pkg::S_RX2;
        end
      end
      mes_pkg::S_RX2:   state_d = mes_pkg::S_RY2;
      mes_pkg::S_RY2:   state_d = restart_q ? mes_pkg::S_RXY : mes_pkg::S_CAPRY;
      mes_pkg::S_RXY:   state_d = mes_pkg::S_INIT;
      mes_pkg::S_INIT:  state_d = mes_pkg::S_EMIT;
      mes_pkg::S_CAPRY: state_d = mes_pkg::S_STEP;
      mes_pkg::S_STEP: begin
        if (!region_q && !r1_step) state_d = mes_pkg::S_TX2;
        else                       state_d = mes_pkg::S_EMIT;
      end
      mes_pkg::S_TX2:   state_d = mes_pkg::S_YM2;
      mes_pkg::S_YM2:   state_d = mes_pkg::S_PA;
      mes_pkg::S_PA:    state_d = mes_pkg::S_PB;
      mes_pkg::S_PB:    state_d = mes_pkg::S_PC;
      mes_pkg::S_PC:    state_d = mes_pkg::S_SUM;
      mes_pkg::S_SUM:   state_d = mes_pkg::S_ROUND;
      mes_pkg::S_ROUND: state_d = mes_pkg::S_STEP;
      mes_pkg::S_EMIT: begin
        if (emit_go) state_d = mes_pkg::S_IDLE;
      end
      default: state_d = mes_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mes_pkg::S_IDLE;
      radius_x_q <= '0;
      radius_y_q <= '0;
      centre_x_q <= '0;
      centre_y_q <= '0;
      step_x_q   <= '0;
      step_y_q   <= '0;
      decision_q <= '0;
      x_slope_q  <= '0;
      y_slope_q  <= '0;
      region_q   <= 1'b0;
      finished_q <= 1'b1;
      restart_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mes_pkg::REG_RADIUS_X: radius_x_q <= cfg_data_i[R-1:0];
          mes_pkg::REG_RADIUS_Y: radius_y_q <= cfg_data_i[R-1:0];
          mes_pkg::REG_CENTRE_X: centre_x_q <= $signed(cfg_data_i[mes_pkg::CEN_W-1:0]);
          mes_pkg::REG_CENTRE_Y: centre_y_q <= $signed(cfg_data_i[mes_pkg::CEN_W-1:0]);
          default: ;
        endcase
      end

      if (in_acc) restart_q <= restart_i;

      if (state_q == mes_pkg::S_INIT) begin
        step_x_q   <= '0;
        step_y_q   <= SW'(radius_y_q);
        x_slope_q  <= '0;
        y_slope_q  <= LW'(prod) << 1;
        decision_q <= mes_pkg::quarter_round((DW'(ry2_q) << 2) - (DW'(prod) << 2)
                                             + DW'(rx2_q));
        region_q   <= 1'b0;
        finished_q <= (radius_y_q == '0);
      end else if (state_q == mes_pkg::S_ROUND) begin
        decision_q <= mes_pkg::quarter_round(acc_q);
        region_q   <= 1'b1;
      end else if ((state_q == mes_pkg::S_STEP) && (region_q || r1_step)) begin
        step_x_q   <= nx;
        step_y_q   <= ny;
        x_slope_q  <= nxs;
        y_slope_q  <= nys;
        decision_q <= ndec;
        finished_q <= (ny == '0);
      end

      if (emit_go)                         out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath scratch, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mes_pkg::S_RY2:   rx2_q <= mes_pkg::SQ_W'(prod);
      mes_pkg::S_RXY:   ry2_q <= mes_pkg::SQ_W'(prod);
      mes_pkg::S_CAPRY: ry2_q <= mes_pkg::SQ_W'(prod);
      mes_pkg::S_YM2:   tx2_q <= mes_pkg::MA_W'(prod);
      mes_pkg::S_PA:    ym2_q <= mes_pkg::SQ_W'(prod);
      mes_pkg::S_PB:    acc_q <= DW'(prod);
      mes_pkg::S_PC:    acc_q <= acc_q + (DW'(prod) << 2);
      mes_pkg::S_SUM:   acc_q <= acc_q - (DW'(prod) << 2);
      default: ;
    endcase

    if (emit_go) begin
      pax_q      <= PW'(centre_x_q) + PW'(step_x_q);
      pay_q      <= PW'(centre_y_q) + PW'(step_y_q);
      pbx_q      <= PW'(centre_x_q) - PW'(step_x_q);
      pby_q      <= PW'(centre_y_q) + PW'(step_y_q);
      pcx_q      <= PW'(centre_x_q) - PW'(step_x_q);
      pcy_q      <= PW'(centre_y_q) - PW'(step_y_q);
      pdx_q      <= PW'(centre_x_q) + PW'(step_x_q);
      pdy_q      <= PW'(centre_y_q) - PW'(step_y_q);
      reg2_out_q <= region_q;
      last_out_q <= finished_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pix_a_x_o       = $signed(pax_q);
  assign pix_a_y_o       = $signed(pay_q);
  assign pix_b_x_o       = $signed(pbx_q);
  assign pix_b_y_o       = $signed(pby_q);
  assign pix_c_x_o       = $signed(pcx_q);
  assign pix_c_y_o       = $signed(pcy_q);
  assign pix_d_x_o       = $signed(pdx_q);
  assign pix_d_y_o       = $signed(pdy_q);
  assign in_region_two_o = reg2_out_q;
  assign last_point_o    = last_out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request accepted but sequencer still idle");

  a_finished_at_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> (step_y_q == '0))
    else $error("walk finished with y not at zero");

  a_y_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mes_pkg::S_INIT) |=> (step_y_q <= $past(step_y_q)))
    else $error("y grew outside a restart");

  a_region_leaves_on_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(region_q) |-> ($past(state_q) == mes_pkg::S_INIT))
    else $error("region two left without a restart");

endmodule
